// ===== hw/rtl/lufm_pkg.sv =====
// Shared types and constants for the label union-find merge engine.
`default_nettype none

package lufm_pkg;

  localparam int LBL_W      = 10;
  localparam int NUM_LABELS = 1 << LBL_W;
  localparam int CNT_W      = 11;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CNT_W-1:0] TOTAL_CODES_RST = CNT_W'(1024);
  localparam logic [CNT_W-1:0] MIN_CODES_RST   = CNT_W'(20);

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_CODES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CODES   = CFG_IDX_W'(1);

  localparam logic MODE_MERGE   = 1'b0;
  localparam logic MODE_RESOLVE = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [LBL_W-1:0] label_a;
    logic [LBL_W-1:0] label_b;
    logic             forced;
  } in_word_t;

  typedef struct packed {
    logic [LBL_W-1:0] root_label;
    logic             merged;
    logic             halted;
    logic [CNT_W-1:0] remaining;
  } out_word_t;

  // parent table entry: link-valid bit on top of the parent label
  typedef struct packed {
    logic             link;
    logic [LBL_W-1:0] parent;
  } link_t;

  typedef struct packed {
    logic [LBL_W-1:0] label_a;
    logic [LBL_W-1:0] label_b;
    logic             do_merge;
  } lufm_cmd_t;

  typedef struct packed {
    logic             done;
    logic [LBL_W-1:0] root;
    logic             merged;
  } lufm_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/label_union_find_merge.sv =====
// Label union-find merge engine: channels, counters, stop flag and result register.
//
// Input words (in_valid/in_ready) carry mode, label_a, label_b, forced. Mode 0 merges
// the edge (label_a, label_b); mode 1 resolves label_a to its root. Each word gives
// exactly one output word (out_valid/out_ready): root of label_a, merged, halted and
// the remaining label count after the step.
// Config writes (cfg_valid/cfg_ready, always ready): index 0 total_codes, which
// reloads the remaining count; index 1 min_codes. Write only while idle.
// After reset the parent table is swept clear, one entry per cycle, and in_ready stays
// low until the sweep ends. Config writes are taken during the sweep.
// One word at a time through a table walk (one read and at most one write per cycle);
// the walk grows with the chain lengths of label_a and label_b (label_b only for
// merges that are applied). The result then passes from the core's result register
// through the holding register into the output register.
// A finished word sits in the output register; the next input word is accepted while
// it waits. If the receiver stalls, the following result parks in a holding register
// and the engine waits there until the output slot frees.
`default_nettype none

module label_union_find_merge (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire lufm_pkg::in_word_t              in_word,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output lufm_pkg::out_word_t                  out_word,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lufm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lufm_pkg::CNT_W-1:0]      cfg_data
);
  import lufm_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_BUSY, T_HOLD} state_t;

  state_t           state_r;
  logic [CNT_W-1:0] min_r;
  logic [CNT_W-1:0] remaining_r;
  logic             stop_r;
  out_word_t        pend_r;
  out_word_t        out_r;
  logic             out_valid_r;

  logic             core_ready;
  lufm_cmd_t        cmd;
  lufm_res_t        core_res;
  logic             in_acc;
  logic             stop_set;
  logic             cfg_acc;
  logic             slot_free;
  logic [CNT_W-1:0] rem_next;

  assign in_ready  = core_ready && (state_r == T_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign slot_free = !out_valid_r || out_ready;

  // an unforced edge at or below the floor stops merging, and is not applied
  assign stop_set = (in_word.mode == MODE_MERGE) && !in_word.forced &&
                    (remaining_r <= min_r);

  assign cmd = '{label_a:  in_word.label_a,
                 label_b:  in_word.label_b,
                 do_merge: (in_word.mode == MODE_MERGE) && !stop_r && !stop_set};

  assign rem_next = (core_res.merged && (remaining_r != '0)) ?
                    remaining_r - CNT_W'(1) : remaining_r;

  lufm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_acc),
    .cmd       (cmd),
    .ready     (core_ready),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      min_r       <= MIN_CODES_RST;
      remaining_r <= TOTAL_CODES_RST;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index)
          CFG_TOTAL_CODES: begin
            remaining_r <= cfg_data;
          end
          CFG_MIN_CODES: begin
            min_r <= cfg_data;
          end
          default: begin
          end
        endcase
      end

      // in T_HOLD the slot is either refilled below or still stalled
      if (out_valid_r && out_ready && (state_r != T_HOLD)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        T_IDLE: begin
          if (in_acc) begin
            if (stop_set) begin
              stop_r <= 1'b1;
            end
            state_r <= T_BUSY;
          end
        end
        T_BUSY: begin
          if (core_res.done) begin
            remaining_r <= rem_next;
            pend_r      <= '{root_label: core_res.root, merged: core_res.merged,
                             halted: stop_r, remaining: rem_next};
            state_r     <= T_HOLD;
          end
        end
        T_HOLD: begin
          if (slot_free) begin
            out_r       <= pend_r;
            out_valid_r <= 1'b1;
            state_r     <= T_IDLE;
          end
        end
        default: begin
          state_r <= T_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lufm_core.sv =====
// Parent-link table with a sequencer for root find, path flattening and linking.
`default_nettype none

module lufm_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  input  wire lufm_pkg::lufm_cmd_t cmd,
  output logic                   ready,
  output lufm_pkg::lufm_res_t    res
);
  import lufm_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_FIND, S_FLAT} state_t;

  link_t            mem [NUM_LABELS];
  link_t            rdata_r;

  state_t           state_r, state_nxt;
  logic [LBL_W-1:0] clr_r, clr_nxt;
  logic [LBL_W-1:0] cur_r, cur_nxt;
  logic [LBL_W-1:0] start_r, start_nxt;
  logic [LBL_W-1:0] second_r, second_nxt;
  logic [LBL_W-1:0] root_r, root_nxt;
  logic [LBL_W-1:0] ra_r, ra_nxt;
  logic             phase_b_r, phase_b_nxt;
  logic             do_merge_r, do_merge_nxt;
  lufm_res_t        res_r, res_nxt;

  logic [LBL_W-1:0] rd_addr;
  logic             wr_en;
  logic [LBL_W-1:0] wr_addr;
  link_t            wr_data;

  assign ready = (state_r == S_IDLE);
  assign res   = res_r;

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    cur_nxt      = cur_r;
    start_nxt    = start_r;
    second_nxt   = second_r;
    root_nxt     = root_r;
    ra_nxt       = ra_r;
    phase_b_nxt  = phase_b_r;
    do_merge_nxt = do_merge_r;
    res_nxt      = '{done: 1'b0, root: res_r.root, merged: res_r.merged};
    rd_addr      = cur_r;
    wr_en        = 1'b0;
    wr_addr      = cur_r;
    wr_data      = '{link: 1'b1, parent: root_r};

    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + LBL_W'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          start_nxt    = cmd.label_a;
          cur_nxt      = cmd.label_a;
          second_nxt   = cmd.label_b;
          do_merge_nxt = cmd.do_merge;
          phase_b_nxt  = 1'b0;
          rd_addr      = cmd.label_a;
          state_nxt    = S_FIND;
        end
      end
      S_FIND: begin
        // rdata_r holds the entry of cur_r
        if (rdata_r.link) begin
          cur_nxt = rdata_r.parent;
          rd_addr = rdata_r.parent;
        end else begin
          root_nxt  = cur_r;
          cur_nxt   = start_r;
          rd_addr   = start_r;
          state_nxt = S_FLAT;
        end
      end
      S_FLAT: begin
        if (rdata_r.link && (cur_r != root_r)) begin
          wr_en   = 1'b1;
          wr_addr = cur_r;
          wr_data = '{link: 1'b1, parent: root_r};
          cur_nxt = rdata_r.parent;
          rd_addr = rdata_r.parent;
        end else if (!phase_b_r) begin
          ra_nxt = root_r;
          if (do_merge_r) begin
            phase_b_nxt = 1'b1;
            start_nxt   = second_r;
            cur_nxt     = second_r;
            rd_addr     = second_r;
            state_nxt   = S_FIND;
          end else begin
            res_nxt   = '{done: 1'b1, root: root_r, merged: 1'b0};
            state_nxt = S_IDLE;
          end
        end else begin
          // second root found: hang it under the first
          wr_en     = (root_r != ra_r);
          wr_addr   = root_r;
          wr_data   = '{link: 1'b1, parent: ra_r};
          res_nxt   = '{done: 1'b1, root: ra_r, merged: (root_r != ra_r)};
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      res_r      <= '0;
      phase_b_r  <= 1'b0;
      do_merge_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      res_r      <= res_nxt;
      phase_b_r  <= phase_b_nxt;
      do_merge_r <= do_merge_nxt;
    end
    cur_r    <= cur_nxt;
    start_r  <= start_nxt;
    second_r <= second_nxt;
    root_r   <= root_nxt;
    ra_r     <= ra_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lufm_checker.sv =====
// Port-level checks for the label union-find merge engine, bound to the top level.
`default_nettype none

module lufm_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire lufm_pkg::out_word_t out_word
);
  import lufm_pkg::*;

  // table sweep keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("input ready during table clear");

  // one word at a time: ready drops after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted back to back");

  // a merge never happens once halted
  a_merge_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.merged) |-> !out_word.halted)
    else $error("merged word reports halted");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
    else $error("output word changed while stalled");

endmodule

bind label_union_find_merge lufm_checker u_lufm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

`default_nettype wire
